// ===== hw/rtl/ptt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Package for the pressure tendency tracker: field widths, reset values,
// register and tendency codes, and the cell control struct.
// No dependencies.
package ptt_pkg;

  localparam int unsigned PressW   = 17;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned DeltaW   = 18;
  localparam int unsigned ThrW     = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  localparam int unsigned HistoryDepthDef = 36;

  localparam logic [TimeW-1:0] LogIntervalRst = 32'd300000;
  localparam logic [ThrW-1:0]  StormDropRst   = 16'd300;
  localparam logic [ThrW-1:0]  FallDropRst    = 16'd100;
  localparam logic [ThrW-1:0]  RiseGainRst    = 16'd100;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LOG_INTERVAL = 2'd0,
    CFG_STORM_DROP   = 2'd1,
    CFG_FALL_DROP    = 2'd2,
    CFG_RISE_GAIN    = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    TEND_STEADY  = 2'd0,
    TEND_RISING  = 2'd1,
    TEND_FALLING = 2'd2,
    TEND_STORM   = 2'd3
  } tendency_e;

  // Per-cycle command to every history cell.
  typedef struct packed {
    logic shift;     // take the neighbor's value
    logic load_all;  // take the broadcast value
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ptt_intf.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel interfaces of the pressure tendency tracker:
// sample input, result output and configuration write. Depends on ptt_pkg.

interface ptt_in_if;
  logic                        valid;
  logic                        ready;
  logic [ptt_pkg::PressW-1:0]  pressure_pa;
  logic [ptt_pkg::TimeW-1:0]   now_ms;
  modport source (output valid, pressure_pa, now_ms, input ready);
  modport sink   (input valid, pressure_pa, now_ms, output ready);
endinterface

interface ptt_out_if;
  logic                        valid;
  logic                        ready;
  logic [ptt_pkg::DeltaW-1:0]  delta_pa;
  logic [1:0]                  tendency;
  logic                        sample_logged;
  modport source (output valid, delta_pa, tendency, sample_logged, input ready);
  modport sink   (input valid, delta_pa, tendency, sample_logged, output ready);
endinterface

interface ptt_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ptt_pkg::CfgIdxW-1:0]   index;
  logic [ptt_pkg::CfgDataW-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ptt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One history cell: holds a pressure sample, loads the broadcast value or
// its neighbor's value. Depends on ptt_pkg.
module ptt_cell (
  input  logic                        clk_i,
  input  ptt_pkg::cell_ctrl_t         ctrl_i,
  input  logic [ptt_pkg::PressW-1:0]  fill_i,
  input  logic [ptt_pkg::PressW-1:0]  prev_i,
  output logic [ptt_pkg::PressW-1:0]  data_o
);
  import ptt_pkg::*;

  logic [PressW-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.load_all) begin
      data_d = fill_i;
    end else if (ctrl_i.shift) begin
      data_d = prev_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule
`default_nettype wire

// ===== hw/rtl/ptt_chain.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Row of history cells, newest at the head, oldest at the tail.
// Depends on ptt_pkg and ptt_cell.
module ptt_chain #(
  parameter int unsigned HISTORY_DEPTH = ptt_pkg::HistoryDepthDef
) (
  input  logic                        clk_i,
  input  ptt_pkg::cell_ctrl_t         ctrl_i,
  input  logic [ptt_pkg::PressW-1:0]  sample_i,
  output logic [ptt_pkg::PressW-1:0]  tail_o,
  output logic [ptt_pkg::PressW-1:0]  pretail_o
);
  import ptt_pkg::*;

  logic [PressW-1:0] taps [HISTORY_DEPTH];

  for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_cell
    logic [PressW-1:0] prev;
    if (g == 0) begin : g_head
      assign prev = sample_i;
    end else begin : g_body
      assign prev = taps[g-1];
    end
    ptt_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl_i),
      .fill_i (sample_i),
      .prev_i (prev),
      .data_o (taps[g])
    );
  end

  assign tail_o    = taps[HISTORY_DEPTH-1];
  assign pretail_o = taps[HISTORY_DEPTH-2];

endmodule
`default_nettype wire

// ===== hw/rtl/pressure_tendency_tracker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Pressure tendency tracker: one result per sample, held in stage 1 and then in the
// result register; one request accepted every cycle while results drain.
// Rate is set by the log decision (32-bit timestamp compare) and the one-cell
// shift of the history row, both done in the accept cycle.
// Reset (async, active low) clears control and registers to their defaults;
// history needs no clearing: the first logged sample fills the whole row.
module pressure_tendency_tracker #(
  parameter int unsigned HISTORY_DEPTH = ptt_pkg::HistoryDepthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ptt_in_if.sink       sample_i,
  ptt_out_if.source    result_o,
  ptt_cfg_if.sink      cfg_i
);
  import ptt_pkg::*;

  // Configuration registers.
  logic [TimeW-1:0] log_interval_q;
  logic [ThrW-1:0]  storm_drop_q, fall_drop_q, rise_gain_q;

  // Log bookkeeping: time of last store, and whether anything was stored yet.
  logic [TimeW-1:0] last_log_q, last_log_d;
  logic             logged_any_q, logged_any_d;

  // Stage 1: sample and the oldest entry as seen after this request's store.
  logic              s1_v_q, s1_v_d;
  logic [PressW-1:0] s1_press_q, s1_oldest_q;
  logic              s1_logged_q;

  // Stage 2: result register.
  logic                     out_v_q, out_v_d;
  logic signed [DeltaW-1:0] out_delta_q;
  tendency_e                out_tend_q;
  logic                     out_logged_q;

  logic              in_acc, s1_adv, store;
  logic [TimeW-1:0]  elapsed;
  logic [PressW-1:0] tail, pretail, oldest;
  cell_ctrl_t        cell_ctrl;

  logic signed [DeltaW-1:0] delta, storm_neg, fall_neg, rise_pos;
  tendency_e                tend;

  // ---------------------------------------------------------------- config
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log_interval_q <= LogIntervalRst;
      storm_drop_q   <= StormDropRst;
      fall_drop_q    <= FallDropRst;
      rise_gain_q    <= RiseGainRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        CFG_LOG_INTERVAL: log_interval_q <= cfg_i.data;
        CFG_STORM_DROP:   storm_drop_q   <= cfg_i.data[ThrW-1:0];
        CFG_FALL_DROP:    fall_drop_q    <= cfg_i.data[ThrW-1:0];
        CFG_RISE_GAIN:    rise_gain_q    <= cfg_i.data[ThrW-1:0];
        default:          ;
      endcase
    end
  end

  // ------------------------------------------------------- handshake flow
  // Stage 1 advances whenever the result register is empty or being taken.
  assign s1_adv         = !out_v_q || result_o.ready;
  assign sample_i.ready = !s1_v_q || s1_adv;
  assign in_acc         = sample_i.valid && sample_i.ready;

  // ------------------------------------------------------- log decision
  // Wrapping difference; the very first request always stores.
  assign elapsed = sample_i.now_ms - last_log_q;
  assign store   = !logged_any_q || (elapsed >= log_interval_q);

  // First store broadcasts into every cell, so the tail holds the first
  // sample until the row has turned over once; later stores shift.
  assign cell_ctrl.load_all = in_acc && !logged_any_q;
  assign cell_ctrl.shift    = in_acc && logged_any_q && store;

  ptt_chain #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_chain (
    .clk_i     (clk_i),
    .ctrl_i    (cell_ctrl),
    .sample_i  (sample_i.pressure_pa),
    .tail_o    (tail),
    .pretail_o (pretail)
  );

  // Oldest entry after this request's store: the next-to-last cell moves to
  // the tail on a shift, the sample itself fills the row on the first store.
  always_comb begin
    priority if (!store) begin
      oldest = tail;
    end else if (!logged_any_q) begin
      oldest = sample_i.pressure_pa;
    end else begin
      oldest = pretail;
    end
  end

  always_comb begin
    last_log_d   = last_log_q;
    logged_any_d = logged_any_q;
    if (in_acc) begin
      logged_any_d = 1'b1;
      if (store) begin
        last_log_d = sample_i.now_ms;
      end
    end
  end

  always_comb begin
    s1_v_d = s1_v_q;
    if (sample_i.ready) begin
      s1_v_d = in_acc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_log_q   <= '0;
      logged_any_q <= 1'b0;
      s1_v_q       <= 1'b0;
    end else begin
      last_log_q   <= last_log_d;
      logged_any_q <= logged_any_d;
      s1_v_q       <= s1_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_press_q  <= sample_i.pressure_pa;
      s1_oldest_q <= oldest;
      s1_logged_q <= store;
    end
  end

  // ------------------------------------------------------- classification
  assign delta     = $signed({1'b0, s1_press_q}) - $signed({1'b0, s1_oldest_q});
  assign storm_neg = -$signed({{(DeltaW-ThrW){1'b0}}, storm_drop_q});
  assign fall_neg  = -$signed({{(DeltaW-ThrW){1'b0}}, fall_drop_q});
  assign rise_pos  = $signed({{(DeltaW-ThrW){1'b0}}, rise_gain_q});

  // Order decides: storm before falling before rising.
  always_comb begin
    priority if (delta <= storm_neg) begin
      tend = TEND_STORM;
    end else if (delta <= fall_neg) begin
      tend = TEND_FALLING;
    end else if (delta >= rise_pos) begin
      tend = TEND_RISING;
    end else begin
      tend = TEND_STEADY;
    end
  end

  always_comb begin
    out_v_d = out_v_q;
    if (s1_adv) begin
      out_v_d = s1_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_v_q) begin
      out_delta_q  <= delta;
      out_tend_q   <= tend;
      out_logged_q <= s1_logged_q;
    end
  end

  assign result_o.valid         = out_v_q;
  assign result_o.delta_pa      = out_delta_q;
  assign result_o.tendency      = out_tend_q;
  assign result_o.sample_logged = out_logged_q;

  // ------------------------------------------------------- assertions
  // First request stores and sees itself as the oldest entry.
  a_first_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !logged_any_q) |=> (s1_logged_q && (s1_oldest_q == s1_press_q)))
    else $error("first request not stored as its own oldest entry");

  // Once anything is stored, the history never reads as empty again.
  a_logged_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    logged_any_q |=> logged_any_q)
    else $error("stored flag dropped");

  // Rising needs a non-negative delta.
  a_rise_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && (out_tend_q == TEND_RISING)) |-> !out_delta_q[DeltaW-1])
    else $error("rising result with negative delta");

  // Falling and storm need a delta of zero or below.
  a_drop_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && ((out_tend_q == TEND_FALLING) || (out_tend_q == TEND_STORM)))
      |-> (out_delta_q[DeltaW-1] || (out_delta_q == '0)))
    else $error("drop result with positive delta");

endmodule
`default_nettype wire

// ===== dv/tb_pressure_tendency_tracker.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for pressure_tendency_tracker: directed and random sample
// streams with a built-in tendency predictor and a scoreboard on the result channel.
// Depends on ptt_pkg, the ptt_*_if interfaces and the tracker RTL.
module tb_pressure_tendency_tracker;
  import ptt_pkg::*;

  localparam int unsigned       HistDepth = HistoryDepthDef;
  localparam logic [PressW-1:0] StdAtmPa  = 17'd101325;
  localparam logic [PressW-1:0] PressMax  = '1;
  localparam int                ShownMax  = 10;

  // One expected result: what the tracker must report for one accepted request.
  typedef struct packed {
    logic [DeltaW-1:0] delta_pa;
    tendency_e         tendency;
    logic              logged;
  } reading_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ptt_in_if  sample_bus ();
  ptt_out_if result_bus ();
  ptt_cfg_if cfg_bus ();

  pressure_tendency_tracker #(
    .HISTORY_DEPTH(HistDepth)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sample_i(sample_bus),
    .result_o(result_bus),
    .cfg_i   (cfg_bus)
  );

  always #2 clk_i = ~clk_i;

  // Predictor state: its own copy of the history ring and the register file.
  logic [PressW-1:0] hist_pa [HistDepth];
  int unsigned       next_slot;
  bit                wrapped;
  logic [TimeW-1:0]  last_store_ms;
  logic [TimeW-1:0]  gap_ms;
  logic [ThrW-1:0]   storm_pa;
  logic [ThrW-1:0]   fall_pa;
  logic [ThrW-1:0]   rise_pa;

  reading_t readings_due [$];

  // Stimulus state and knobs shared by the test tasks.
  logic [PressW-1:0] walk_pa  = StdAtmPa;
  logic [TimeW-1:0]  clock_ms = '0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_off_req   = 0;
  int hold_left      = 0;

  // Run statistics.
  int mismatches   = 0;
  int results_seen = 0;
  int samples_sent = 0;
  int logged_count = 0;
  int cfg_writes   = 0;
  int tend_seen [4] = '{default: 0};

  reading_t got_reading;
  reading_t want_reading;

  // Advance the predictor by one sample: store first, then read the oldest entry and
  // classify the difference. Storm is checked before falling, falling before rising.
  function automatic reading_t predict_reading(input logic [PressW-1:0] p,
                                               input logic [TimeW-1:0]  t);
    reading_t         r;
    logic [TimeW-1:0] elapsed;
    int unsigned      oldest;
    int               d;
    elapsed  = t - last_store_ms;
    // Nothing stored yet forces a store, whatever the timestamp says.
    r.logged = ((next_slot == 0) && !wrapped) || (elapsed >= gap_ms);
    if (r.logged) begin
      last_store_ms      = t;
      hist_pa[next_slot] = p;
      next_slot++;
      if (next_slot == HistDepth) begin
        next_slot = 0;
        wrapped   = 1'b1;
      end
      logged_count++;
    end
    // Slot 0 stays the oldest until the ring has gone round once.
    oldest     = wrapped ? next_slot : 0;
    d          = int'(p) - int'(hist_pa[oldest]);
    r.delta_pa = d[DeltaW-1:0];
    if (d <= -int'(storm_pa)) begin
      r.tendency = TEND_STORM;
    end else if (d <= -int'(fall_pa)) begin
      r.tendency = TEND_FALLING;
    end else if (d >= int'(rise_pa)) begin
      r.tendency = TEND_RISING;
    end else begin
      r.tendency = TEND_STEADY;
    end
    return r;
  endfunction

  // Offer one sample request, idling first at the current rate, and hold it until
  // accepted. Valid stays high afterwards so back-to-back requests need no gap.
  task automatic send_sample(input logic [PressW-1:0] p, input logic [TimeW-1:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_bus.valid       <= 1'b1;
    sample_bus.pressure_pa <= p;
    sample_bus.now_ms      <= t;
    @(posedge clk_i);
    while (!sample_bus.ready) @(posedge clk_i);
    readings_due.push_back(predict_reading(p, t));
    samples_sent++;
  endtask

  task automatic wait_readings_drained();
    while (readings_due.size() != 0) @(posedge clk_i);
  endtask

  // Write all four registers while the tracker is idle. With noisy set, the unused
  // upper bits of the threshold writes carry random data that must be dropped.
  task automatic program_regs(input logic [TimeW-1:0] interval,
                              input logic [ThrW-1:0]  storm,
                              input logic [ThrW-1:0]  fall,
                              input logic [ThrW-1:0]  rise,
                              input bit               noisy);
    cfg_reg_e            idx;
    logic [CfgDataW-1:0] word;
    logic [ThrW-1:0]     junk;
    int                  k;
    wait_readings_drained();
    for (k = 0; k < 4; k++) begin
      idx  = cfg_reg_e'(k);
      junk = noisy ? ThrW'($urandom) : '0;
      case (idx)
        CFG_LOG_INTERVAL: word = interval;
        CFG_STORM_DROP:   word = {junk, storm};
        CFG_FALL_DROP:    word = {junk, fall};
        default:          word = {junk, rise};
      endcase
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= idx;
      cfg_bus.data  <= word;
      @(posedge clk_i);
      while (!cfg_bus.ready) @(posedge clk_i);
      case (idx)
        CFG_LOG_INTERVAL: gap_ms   = word;
        CFG_STORM_DROP:   storm_pa = word[ThrW-1:0];
        CFG_FALL_DROP:    fall_pa  = word[ThrW-1:0];
        default:          rise_pa  = word[ThrW-1:0];
      endcase
      cfg_writes++;
    end
    cfg_bus.valid <= 1'b0;
  endtask

  // Random sample: pressure mostly walks near its last value so deltas land around
  // the thresholds; timestamps mostly step near the interval, sometimes land exactly
  // on (or one short of) the next store point, and sometimes jump anywhere.
  task automatic send_random_sample();
    int               w;
    int unsigned      pick;
    logic [TimeW-1:0] lim;
    pick = $urandom_range(99);
    if (pick < 6) begin
      walk_pa = PressW'($urandom_range(0, PressMax));
    end else begin
      w       = int'(walk_pa) + int'($urandom_range(0, 800)) - 400;
      walk_pa = (w < 0) ? '0 : (w > int'(PressMax)) ? PressMax : PressW'(w);
    end
    pick = $urandom_range(99);
    lim  = (gap_ms > 32'h7FFF_FFFF) ? '1 : (gap_ms == 0) ? TimeW'(4) : gap_ms << 1;
    if (pick < 8) begin
      clock_ms = $urandom;
    end else if (pick < 16) begin
      clock_ms = last_store_ms + gap_ms - TimeW'($urandom_range(0, 1));
    end else if (pick < 35) begin
      clock_ms = clock_ms + TimeW'($urandom_range(0, 3));
    end else begin
      clock_ms = clock_ms + TimeW'($urandom_range(0, lim));
    end
    send_sample(walk_pa, clock_ms);
  endtask

  // Reset defaults: first sample, each tendency at its threshold edge, exact interval,
  // pressure extremes and a store decision across the timestamp wrap.
  task automatic test_first_sample();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_sample(StdAtmPa, '0);                        // first sample stores at time zero
    send_sample(StdAtmPa - 17'd300, 32'd5);           // zero stamp does not force a store
    send_sample(StdAtmPa - 17'd299, 32'd6);
    send_sample(StdAtmPa - 17'd100, 32'd7);
    send_sample(StdAtmPa - 17'd99, 32'd8);
    send_sample(StdAtmPa + 17'd100, 32'd9);
    send_sample(StdAtmPa + 17'd99, 32'd10);
    send_sample('0, 32'd299999);                      // one short of the interval
    send_sample(PressMax, 32'd300000);                // exactly the interval
    send_sample(17'd101000, 32'hFFFF_FFFF);
    send_sample(17'd101000, 32'd299998);              // wrapped, still one short
    send_sample(17'd101000, 32'd299999);              // wrapped, exactly the interval
    sample_bus.valid <= 1'b0;
  endtask

  // Interval zero stores everything and zero thresholds flag any drop as a storm;
  // then the widest interval and thresholds.
  task automatic test_threshold_extremes();
    program_regs('0, '0, '0, '0, 1'b1);
    send_sample(17'd100, 32'd1234);
    send_sample(PressMax, 32'd1234);
    send_sample(StdAtmPa, 32'd1234);
    send_sample(StdAtmPa + 17'd1, 32'd1234);
    sample_bus.valid <= 1'b0;
    program_regs('1, '1, '1, '1, 1'b0);
    send_sample('0, 32'd1233);                        // elapsed is all ones: stores
    send_sample(PressMax, 32'd1232);
    send_sample(17'd50000, 32'd5);
    send_sample(17'd35790, 32'd6);
    send_sample(17'd35791, 32'd7);
    sample_bus.valid <= 1'b0;
  endtask

  // Blocks of random samples, each under a freshly drawn register setting.
  task automatic test_random_traffic(input int n_samples, input int idle_pct,
                                     input int stall_pct);
    int               left;
    int               blk;
    logic [TimeW-1:0] interval;
    logic [ThrW-1:0]  thr [3];
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    left           = n_samples;
    while (left > 0) begin
      case ($urandom_range(0, 5))
        0:       interval = LogIntervalRst;
        1:       interval = '0;
        2:       interval = '1;
        3:       interval = $urandom;
        default: interval = TimeW'($urandom_range(1, 20));
      endcase
      foreach (thr[j]) begin
        case ($urandom_range(0, 9))
          0:       thr[j] = '0;
          1:       thr[j] = '1;
          2:       thr[j] = ThrW'($urandom_range(0, 65535));
          default: thr[j] = ThrW'($urandom_range(20, 600));
        endcase
      end
      program_regs(interval, thr[0], thr[1], thr[2], bit'($urandom_range(0, 1)));
      blk = $urandom_range(40, 90);
      if (blk > left) blk = left;
      repeat (blk) send_random_sample();
      sample_bus.valid <= 1'b0;
      left -= blk;
    end
  endtask

  // Hold results back for a long stretch while requests keep coming, so the tracker
  // fills up and drops its input ready.
  task automatic test_backpressure(input int n_samples);
    program_regs(32'd5, 16'd250, 16'd80, 16'd80, 1'b0);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_req   = 200;
    repeat (n_samples) send_random_sample();
    sample_bus.valid <= 1'b0;
  endtask

  // Result ready: a requested hold-off wins, otherwise stall at the current rate.
  always @(posedge clk_i) begin
    if (hold_off_req != 0) begin
      hold_left    = hold_off_req;
      hold_off_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      result_bus.ready <= 1'b0;
    end else begin
      result_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Scoreboard: compare every accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      got_reading.delta_pa = result_bus.delta_pa;
      got_reading.tendency = tendency_e'(result_bus.tendency);
      got_reading.logged   = result_bus.sample_logged;
      results_seen++;
      if (!$isunknown(result_bus.tendency)) tend_seen[result_bus.tendency]++;
      if (readings_due.size() == 0) begin
        mismatches++;
        if (mismatches <= ShownMax)
          $display("%0t: result with nothing pending: delta %0d tendency %0d logged %0b",
                   $realtime, $signed(got_reading.delta_pa), got_reading.tendency,
                   got_reading.logged);
      end else begin
        want_reading = readings_due.pop_front();
        if (got_reading.delta_pa !== want_reading.delta_pa ||
            got_reading.tendency !== want_reading.tendency ||
            got_reading.logged   !== want_reading.logged) begin
          mismatches++;
          if (mismatches <= ShownMax)
            $display("%0t: result %0d: delta %0d/%0d tendency %0d/%0d logged %0b/%0b %s",
                     $realtime, results_seen, $signed(want_reading.delta_pa),
                     $signed(got_reading.delta_pa), want_reading.tendency,
                     got_reading.tendency, want_reading.logged, got_reading.logged,
                     "(expected/actual)");
        end
      end
    end
  end

  // Watchdog: the slowest legal run needs well under a tenth of this.
  initial begin
    #2ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    sample_bus.valid       = 1'b0;
    sample_bus.pressure_pa = '0;
    sample_bus.now_ms      = '0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.index          = CFG_LOG_INTERVAL;
    cfg_bus.data           = '0;
    result_bus.ready       = 1'b0;
    foreach (hist_pa[i]) hist_pa[i] = StdAtmPa;
    next_slot     = 0;
    wrapped       = 1'b0;
    last_store_ms = '0;
    gap_ms        = LogIntervalRst;
    storm_pa      = StormDropRst;
    fall_pa       = FallDropRst;
    rise_pa       = RiseGainRst;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_first_sample();
    test_threshold_extremes();
    test_random_traffic(480, 30, 65);
    test_random_traffic(480, 65, 30);
    test_random_traffic(440, 0, 0);
    test_backpressure(60);

    // Drain, then let stray results show up before the summary.
    wait_readings_drained();
    repeat (8) @(posedge clk_i);

    $display("Ran %0d samples (%0d stored to history) under %0d register writes.",
             samples_sent, logged_count, cfg_writes);
    $display("Tendencies reported: steady %0d, rising %0d, falling %0d, storm %0d.",
             tend_seen[TEND_STEADY], tend_seen[TEND_RISING], tend_seen[TEND_FALLING],
             tend_seen[TEND_STORM]);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
